/* sv/consistent_hash_node_picker_core_defines.svh */
// assertion macros for the node picker checker
// no dependencies; included by the checker file
`ifndef CONSISTENT_HASH_NODE_PICKER_CORE_DEFINES_SVH
`define CONSISTENT_HASH_NODE_PICKER_CORE_DEFINES_SVH

// checked only outside reset
`define CHNP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CHNP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/chnp_pkg.sv */
// shared types, constants and hash helpers for the node picker
// no dependencies
package chnp_pkg;

  localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
  localparam int unsigned TabDepth = 64;
  localparam int unsigned PrefixLen = 9;
  localparam int unsigned BcdDigits = 20;

  typedef enum logic [1:0] {
    REG_NODE_COUNT = 2'd0,
    REG_THIS_NODE  = 2'd1,
    REG_DEAD_MASK  = 2'd2,
    REG_SPARE      = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    F_IDLE, F_CONV, F_DIGIT, F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE, B_SCAN, B_DONE
  } back_state_t;

  typedef struct packed {
    logic [63:0] wh;
    logic [63:0] excl;
  } work_entry_t;

  typedef struct packed {
    logic [5:0] owner;
    logic       is_local;
    logic       no_live;
  } result_t;

  typedef logic [63:0] hash_tab_t [TabDepth];

  // xor then multiply by the fnv prime, 2^40 + 0x1b3, as shifts and adds
  function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = "r";
      4'd1: c = "e";
      4'd2: c = "a";
      4'd3: c = "c";
      4'd4: c = "t";
      4'd5: c = "i";
      4'd6: c = "o";
      4'd7: c = "n";
      4'd8: c = ":";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // ring positions of "node:<i>", worked out at elaboration
  function automatic hash_tab_t build_node_hashes();
    hash_tab_t t;
    logic [63:0] h;
    for (int i = 0; i < TabDepth; i++) begin
      h = FnvBasis;
      h = fnv_mix(h, "n");
      h = fnv_mix(h, "o");
      h = fnv_mix(h, "d");
      h = fnv_mix(h, "e");
      h = fnv_mix(h, ":");
      if (i >= 10) h = fnv_mix(h, 8'(8'h30 + i / 10));
      h = fnv_mix(h, 8'(8'h30 + i % 10));
      t[i] = h;
    end
    return t;
  endfunction

  localparam hash_tab_t NodeHash = build_node_hashes();

  // one double dabble step: adjust digits, shift in the next binary bit
  function automatic logic [4*BcdDigits-1:0] dabble(input logic [4*BcdDigits-1:0] bcd,
                                                   input logic bit_in);
    logic [4*BcdDigits-1:0] a;
    for (int k = 0; k < BcdDigits; k++) begin
      a[4*k +: 4] = (bcd[4*k +: 4] >= 4'd5) ? bcd[4*k +: 4] + 4'd3 : bcd[4*k +: 4];
    end
    return {a[4*BcdDigits-2:0], bit_in};
  endfunction

endpackage

/* sv/chnp_fifo.sv */
// two-entry queue of opaque beats between pipeline parts
// no dependencies
module chnp_fifo #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  output logic             full,
  input  logic [Width-1:0] wdata,
  input  logic             rd_en,
  output logic             empty,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem_r [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_en && !full) wptr_r <= ~wptr_r;
      if (rd_en && !empty) rptr_r <= ~rptr_r;
      case ({wr_en && !full, rd_en && !empty})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem_r[wptr_r] <= wdata;
  end

endmodule

/* sv/chnp_front.sv */
// front part: takes work ids, forms the decimal label and hashes it
// depends on chnp_pkg
module chnp_front import chnp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [63:0] work_id,
  input  logic        use_exclusions,
  input  logic        extra_dead_valid,
  input  logic [5:0]  extra_dead_node,
  input  logic [63:0] dead_mask,
  output logic        q_push,
  input  logic        q_full,
  output work_entry_t q_data
);

  front_state_t state_r, state_nxt;
  logic [63:0]  bin_r;
  logic [79:0]  bcd_r;
  logic [63:0]  h_r;
  logic [63:0]  excl_r;
  logic [5:0]   cnt_r;
  logic [4:0]   dig_r;
  logic         started_r;
  logic [3:0]   cur_digit;

  assign cur_digit = bcd_r[{dig_r, 2'b00} +: 4];
  assign full      = (state_r != F_IDLE);
  assign q_push    = (state_r == F_PUSH);
  assign q_data    = '{wh: h_r, excl: excl_r};

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (push) state_nxt = F_CONV;
      F_CONV:  if (cnt_r == 6'd63) state_nxt = F_DIGIT;
      F_DIGIT: if (dig_r == 5'd0) state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        bin_r     <= work_id;
        bcd_r     <= '0;
        h_r       <= FnvBasis;
        cnt_r     <= '0;
        dig_r     <= 5'(BcdDigits - 1);
        started_r <= 1'b0;
        excl_r    <= use_exclusions
                   ? (dead_mask | ({63'd0, extra_dead_valid} << extra_dead_node)) : '0;
      end
      F_CONV: begin
        bcd_r <= dabble(bcd_r, bin_r[63]);
        bin_r <= {bin_r[62:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
        // prefix bytes hash while the conversion runs
        if (cnt_r < 6'(PrefixLen)) h_r <= fnv_mix(h_r, prefix_byte(cnt_r[3:0]));
      end
      F_DIGIT: begin
        // skip leading zeros, but a lone zero still counts
        if (cur_digit != 4'd0 || started_r || dig_r == 5'd0) begin
          h_r       <= fnv_mix(h_r, {4'h3, cur_digit});
          started_r <= 1'b1;
        end
        dig_r <= dig_r - 5'd1;
      end
      default: ;
    endcase
  end

endmodule

/* sv/chnp_back.sv */
// back part: walks the ring for the owner of one work hash
// depends on chnp_pkg
module chnp_back import chnp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  output logic        q_pop,
  input  work_entry_t q_data,
  input  logic [6:0]  ring_count,
  input  logic [5:0]  this_node,
  output logic        r_push,
  input  logic        r_full,
  output result_t     r_data
);

  back_state_t state_r, state_nxt;
  logic [63:0] wh_r, excl_r;
  logic [6:0]  idx_r;
  logic        any_r, up_r;
  logic [63:0] lo_h_r, up_h_r;
  logic [5:0]  lo_i_r, up_i_r;
  logic [63:0] cur_h;
  logic [5:0]  owner;

  assign cur_h  = NodeHash[idx_r[5:0]];
  assign q_pop  = (state_r == B_IDLE) && !q_empty;
  assign r_push = (state_r == B_DONE);
  assign owner  = up_r ? up_i_r : (any_r ? lo_i_r : 6'd0);
  assign r_data = '{owner: owner, is_local: any_r && (owner == this_node), no_live: !any_r};

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (!q_empty) state_nxt = B_SCAN;
      B_SCAN:  if (idx_r >= ring_count) state_nxt = B_DONE;
      B_DONE:  if (!r_full) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        wh_r   <= q_data.wh;
        excl_r <= q_data.excl;
        idx_r  <= '0;
        any_r  <= 1'b0;
        up_r   <= 1'b0;
      end
      B_SCAN: begin
        if (idx_r < ring_count && !excl_r[idx_r[5:0]]) begin
          // strict compares keep the smaller index on equal hashes
          if (!any_r || cur_h < lo_h_r) begin
            lo_h_r <= cur_h;
            lo_i_r <= idx_r[5:0];
            any_r  <= 1'b1;
          end
          if (cur_h >= wh_r && (!up_r || cur_h < up_h_r)) begin
            up_h_r <= cur_h;
            up_i_r <= idx_r[5:0];
            up_r   <= 1'b1;
          end
        end
        if (idx_r < ring_count) idx_r <= idx_r + 7'd1;
      end
      default: ;
    endcase
  end

endmodule

/* sv/consistent_hash_node_picker_core.sv */
// channel  | handshake            | beat
// in       | push / full          | in_work_id, in_use_exclusions, in_extra_dead_*
// out      | empty / pop          | out_owner_node, out_owner_is_local, out_no_live_node
// cfg      | psel/penable/pwrite  | paddr (8-byte regs), pwdata, prdata
//
// the front works on one beat at a time: it takes the beat, runs 64 double dabble
// steps and 20 digit slots (one fnv round per digit past leading zeros), then
// hands it to the queue. the back pops a beat, scans the ring and hands off.
// front and back overlap through a two-entry queue; a 2-entry result queue
// frees the back while out is stalled. reset is synchronous, active low,
// and leaves node_count = 1, this_node = 0, dead_mask = 0.
module consistent_hash_node_picker_core import chnp_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [63:0] in_work_id,
  input  logic        in_use_exclusions,
  input  logic        in_extra_dead_valid,
  input  logic [5:0]  in_extra_dead_node,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  out_owner_node,
  output logic        out_owner_is_local,
  output logic        out_no_live_node,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [6:0]  node_count_r;
  logic [5:0]  this_node_r;
  logic [63:0] dead_mask_r;
  logic [6:0]  ring_count;
  reg_idx_t    reg_sel;
  logic        q_push, q_full, q_pop, q_empty;
  work_entry_t q_wdata, q_rdata;
  logic        r_push, r_full;
  result_t     r_wdata, r_rdata;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 7'd1;
      this_node_r  <= '0;
      dead_mask_r  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_NODE_COUNT: node_count_r <= pwdata[6:0];
        REG_THIS_NODE:  this_node_r  <= pwdata[5:0];
        REG_DEAD_MASK:  dead_mask_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NODE_COUNT: prdata = {57'd0, node_count_r};
      REG_THIS_NODE:  prdata = {58'd0, this_node_r};
      REG_DEAD_MASK:  prdata = dead_mask_r;
      default:        prdata = '0;
    endcase
  end

  assign ring_count = (node_count_r > 7'(MAX_NODES)) ? 7'(MAX_NODES) : node_count_r;

  chnp_front u_front (
    .clk, .rst_n, .push, .full,
    .work_id(in_work_id), .use_exclusions(in_use_exclusions),
    .extra_dead_valid(in_extra_dead_valid), .extra_dead_node(in_extra_dead_node),
    .dead_mask(dead_mask_r),
    .q_push, .q_full, .q_data(q_wdata)
  );

  chnp_fifo #(.Width($bits(work_entry_t))) u_work_q (
    .clk, .rst_n, .wr_en(q_push), .full(q_full), .wdata(q_wdata),
    .rd_en(q_pop), .empty(q_empty), .rdata(q_rdata)
  );

  chnp_back u_back (
    .clk, .rst_n, .q_empty, .q_pop, .q_data(q_rdata),
    .ring_count, .this_node(this_node_r),
    .r_push, .r_full, .r_data(r_wdata)
  );

  chnp_fifo #(.Width($bits(result_t))) u_res_q (
    .clk, .rst_n, .wr_en(r_push), .full(r_full), .wdata(r_wdata),
    .rd_en(pop), .empty(empty), .rdata(r_rdata)
  );

  assign out_owner_node     = r_rdata.owner;
  assign out_owner_is_local = r_rdata.is_local;
  assign out_no_live_node   = r_rdata.no_live;

endmodule

/* sv/chnp_checker.sv */
// port-level checks on the node picker, bound to the top level
// depends on consistent_hash_node_picker_core_defines.svh
`include "consistent_hash_node_picker_core_defines.svh"

module chnp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic [5:0] out_owner_node,
  input logic       out_owner_is_local,
  input logic       out_no_live_node
);

  `CHNP_ASSERT(a_no_live_zero, !empty && out_no_live_node |-> out_owner_node == 6'd0, "no live node with nonzero owner")
  `CHNP_ASSERT(a_local_live, !empty && out_owner_is_local |-> !out_no_live_node, "local owner flagged with no live node")
  `CHNP_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(out_owner_node), "waiting beat changed")
  `CHNP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> empty, "result queue not empty after reset")

endmodule

bind consistent_hash_node_picker_core chnp_checker u_chnp_checker (
  .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop),
  .out_owner_node(out_owner_node), .out_owner_is_local(out_owner_is_local),
  .out_no_live_node(out_no_live_node)
);
